/* design/gap_pkg.sv */
// Shared types and constants of the grid path search block.
`default_nettype none
package gap_pkg;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } gap_heap_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
    logic overflow;
  } gap_heap_sts_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP,
    H_UP_CMP,
    H_POP_TOP,
    H_POP_LAST,
    H_DN,
    H_DN_L,
    H_DN_R
  } gap_heap_state_e;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_START,
    S_HWAIT,
    S_ADV,
    S_POP,
    S_POP_WAIT,
    S_CUR_RD,
    S_CUR_CHK,
    S_NB,
    S_NB_REC,
    S_SIDE_A,
    S_SIDE_B,
    S_NB_MAP,
    S_GOAL_RD,
    S_GOAL_CHK,
    S_TRACE,
    S_TRACE_W,
    S_EMIT_RD,
    S_EMIT,
    S_NOPATH
  } gap_state_e;

  localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                                -2'sd1, 2'sd1, 2'sd1, -2'sd1};

  localparam int unsigned STEP_STRAIGHT = 1000;
  localparam int unsigned STEP_DIAGONAL = 1414;
  localparam int unsigned OCT_LO        = 414;
  localparam int unsigned OCT_HI        = 1000;
  localparam logic [6:0]  MAX_LEN_RESET = 7'd64;

endpackage
`default_nettype wire

/* design/gap_heap.sv */
// Binary min-heap of open cells held in one synchronous memory.
`default_nettype none
module gap_heap import gap_pkg::*; #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned PRI_W  = 24,
  parameter int unsigned SEQ_W  = 16,
  parameter int unsigned CELL_W = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gap_heap_cmd_t       cmd_i,
  input  wire logic [PRI_W-1:0]    pri_i,
  input  wire logic [CELL_W-1:0]   cell_i,
  output gap_heap_sts_t            sts_o,
  output logic [CELL_W-1:0]        top_cell_o
);

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LW    = IW + 2;
  localparam int unsigned EW    = PRI_W + SEQ_W + CELL_W;

  logic [EW-1:0] mem [DEPTH];
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata_q;

  gap_heap_state_e   state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_m1;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic              ovf_q, ovf_d;
  logic [IW-1:0]     idx_q, idx_d, par_q, par_d, par_w;
  logic [EW-1:0]     item_q, item_d, lval_q, lval_d;
  logic [CELL_W-1:0] top_q, top_d;
  logic [LW-1:0]     l_w, r_w, cnt_w;

  function automatic logic less(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [PRI_W-1:0] pa, pb;
    logic [SEQ_W-1:0] sa, sb;
    pa = a[EW-1 -: PRI_W];
    pb = b[EW-1 -: PRI_W];
    sa = a[CELL_W +: SEQ_W];
    sb = b[CELL_W +: SEQ_W];
    return (pa < pb) || ((pa == pb) && (sa < sb));
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
      seq_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seq_q   <= seq_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    par_q  <= par_d;
    item_q <= item_d;
    lval_q <= lval_d;
    top_q  <= top_d;
  end

  assign l_w    = LW'({idx_q, 1'b1});
  assign r_w    = l_w + LW'(1);
  assign cnt_w  = LW'(cnt_q);
  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign par_w  = (idx_q - IW'(1)) >> 1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    seq_d   = seq_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    par_d   = par_q;
    item_d  = item_q;
    lval_d  = lval_q;
    top_d   = top_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = idx_q;
    wdata   = item_q;
    raddr   = '0;
    case (state_q)
      H_IDLE: begin
        if (cmd_i.clear) begin
          cnt_d = '0;
          seq_d = '0;
          ovf_d = 1'b0;
        end else if (cmd_i.push) begin
          if (cnt_q >= CNT_W'(DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            idx_d   = cnt_q[IW-1:0];
            cnt_d   = cnt_q + CNT_W'(1);
            item_d  = {pri_i, seq_q, cell_i};
            seq_d   = seq_q + SEQ_W'(1);
            state_d = H_UP;
          end
        end else if (cmd_i.pop) begin
          re      = 1'b1;
          state_d = H_POP_TOP;
        end
      end
      H_UP: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          state_d = H_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = par_w;
          par_d   = par_w;
          state_d = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        if (less(item_q, rdata_q)) begin
          wdata   = rdata_q;
          idx_d   = par_q;
          state_d = H_UP;
        end else begin
          state_d = H_IDLE;
        end
      end
      H_POP_TOP: begin
        top_d = rdata_q[CELL_W-1:0];
        cnt_d = cnt_m1;
        if (cnt_m1 == '0) begin
          state_d = H_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = cnt_m1[IW-1:0];
          state_d = H_POP_LAST;
        end
      end
      H_POP_LAST: begin
        item_d  = rdata_q;
        idx_d   = '0;
        state_d = H_DN;
      end
      H_DN: begin
        if (l_w >= cnt_w) begin
          we      = 1'b1;
          state_d = H_IDLE;
        end else begin
          re      = 1'b1;
          raddr   = l_w[IW-1:0];
          state_d = H_DN_L;
        end
      end
      H_DN_L: begin
        lval_d = rdata_q;
        if (r_w < cnt_w) begin
          re      = 1'b1;
          raddr   = r_w[IW-1:0];
          state_d = H_DN_R;
        end else begin
          we = 1'b1;
          if (less(rdata_q, item_q)) begin
            wdata   = rdata_q;
            idx_d   = l_w[IW-1:0];
            state_d = H_DN;
          end else begin
            state_d = H_IDLE;
          end
        end
      end
      H_DN_R: begin
        we = 1'b1;
        if (less(lval_q, item_q)) begin
          if (less(rdata_q, lval_q)) begin
            wdata = rdata_q;
            idx_d = r_w[IW-1:0];
          end else begin
            wdata = lval_q;
            idx_d = l_w[IW-1:0];
          end
          state_d = H_DN;
        end else if (less(rdata_q, item_q)) begin
          wdata   = rdata_q;
          idx_d   = r_w[IW-1:0];
          state_d = H_DN;
        end else begin
          state_d = H_IDLE;
        end
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  assign sts_o.busy     = (state_q != H_IDLE);
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.overflow = ovf_q;
  assign top_cell_o     = top_q;

endmodule
`default_nettype wire

/* design/grid_astar_path_search.sv */
// Top level of the grid path search block: map, cell records, search sequencer and output.
// After reset the map is set passable by a sweep over all GRID_WIDTH*GRID_HEIGHT cells during
// which no item is taken; afterwards map writes and queries are taken one item at a time.
// A query first clears the cell records of all GRID_WIDTH*GRID_HEIGHT cells, then pops each
// cell from the heap and checks its eight neighbors, pushing each improved one onto the heap;
// waypoints are then traced one at a time and sent one at a time.
`default_nettype none
module grid_astar_path_search import gap_pkg::*; #(
  parameter int unsigned GRID_WIDTH    = 64,
  parameter int unsigned GRID_HEIGHT   = 64,
  parameter int unsigned HEAP_DEPTH    = 8192,
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       action_i,
  input  wire logic [5:0] cell_x_i,
  input  wire logic [5:0] cell_y_i,
  input  wire logic       cell_passable_i,
  input  wire logic [5:0] start_x_i,
  input  wire logic [5:0] start_y_i,
  input  wire logic [5:0] goal_x_i,
  input  wire logic [5:0] goal_y_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      way_x_o,
  output logic [5:0]      way_y_o,
  output logic [5:0]      way_index_o,
  output logic [6:0]      path_count_o,
  output logic            no_path_o,
  output logic            heap_overflow_o,
  output logic            last_o
);

  localparam int unsigned XW     = $clog2(GRID_WIDTH);
  localparam int unsigned YW     = $clog2(GRID_HEIGHT);
  localparam int unsigned CW     = XW + YW;
  localparam int unsigned DW     = (XW > YW) ? XW : YW;
  localparam int unsigned CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW     = $clog2(CELLS);
  localparam int unsigned NW     = $clog2(CELLS + 1);
  localparam int unsigned COST_W = AW + 11;
  localparam int unsigned PRI_W  = COST_W + 1;
  localparam int unsigned SEQ_W  = AW + 4;
  localparam int unsigned H_W    = DW + 11;
  localparam int unsigned RW     = 2 + COST_W + CW;
  localparam int unsigned EXW    = NW + 7;

  // Cell record memory: reached, closed, best cost, parent cell.
  logic [RW-1:0] rec_mem [CELLS];
  logic          rec_we, rec_re;
  logic [AW-1:0] rec_waddr, rec_raddr;
  logic [RW-1:0] rec_wdata, rec_rd_q;

  logic          map_mem [CELLS];
  logic          map_we, map_re, map_wdata, map_rd_q;
  logic [AW-1:0] map_waddr, map_raddr;

  logic [CW-1:0] path_mem [CELLS];
  logic          path_we, path_re;
  logic [AW-1:0] path_waddr, path_raddr;
  logic [CW-1:0] path_wdata, path_rd_q;

  gap_state_e      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [XW-1:0]   sx_q, sx_d, gx_q, gx_d, cx_q, cx_d, nx_q, nx_d;
  logic [YW-1:0]   sy_q, sy_d, gy_q, gy_d, cy_q, cy_d, ny_q, ny_d;
  logic [2:0]      d_q, d_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic [H_W-1:0]  h_q, h_d;
  logic [NW-1:0]   n_q, n_d;
  logic [CW-1:0]   tc_q, tc_d;
  logic [6:0]      ei_q, ei_d, emit_q, emit_d;
  logic            ovf_q, ovf_d;
  logic [6:0]      max_len_q;

  logic            out_valid_q, out_load, out_free;
  logic [5:0]      way_x_q, way_y_q, way_index_q;
  logic [6:0]      path_count_q;
  logic            no_path_q, heap_overflow_q, last_q;
  logic [5:0]      ld_x, ld_y, ld_index;
  logic [6:0]      ld_count;
  logic            ld_no_path, ld_ovf, ld_last;

  gap_heap_cmd_t   hcmd;
  gap_heap_sts_t   hsts;
  logic [PRI_W-1:0] hpri;
  logic [CW-1:0]   hcell, htop;

  logic [XW+5:0]   ext_cx, ext_sx, ext_gx;
  logic [YW+5:0]   ext_cy, ext_sy, ext_gy;
  logic [XW+5:0]   ext_wx;
  logic [YW+5:0]   ext_wy;
  logic            cell_in_grid, query_ok;
  logic signed [XW+1:0] nx_s;
  logic signed [YW+1:0] ny_s;
  logic            nb_out;
  logic [XW-1:0]   nx_c;
  logic [YW-1:0]   ny_c;
  logic [COST_W-1:0] new_cost;
  logic [6:0]      limit;
  logic [EXW-1:0]  path_pos;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(int'(y) * GRID_WIDTH + int'(x));
  endfunction

  function automatic logic [H_W-1:0] octile(input logic [XW-1:0] ax, input logic [YW-1:0] ay,
                                            input logic [XW-1:0] bx, input logic [YW-1:0] by);
    logic [DW-1:0] dx, dy, lo, hi;
    dx = DW'((ax > bx) ? ax - bx : bx - ax);
    dy = DW'((ay > by) ? ay - by : by - ay);
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    return H_W'(OCT_LO) * H_W'(lo) + H_W'(OCT_HI) * H_W'(hi);
  endfunction

  gap_heap #(
    .DEPTH  (HEAP_DEPTH),
    .PRI_W  (PRI_W),
    .SEQ_W  (SEQ_W),
    .CELL_W (CW)
  ) u_heap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (hcmd),
    .pri_i      (hpri),
    .cell_i     (hcell),
    .sts_o      (hsts),
    .top_cell_o (htop)
  );

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_raddr];
    end
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_raddr];
    end
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    if (path_re) begin
      path_rd_q <= path_mem[path_raddr];
    end
  end

  assign ext_cx = {6'b0, cell_x_i} ;
  assign ext_cy = {6'b0, cell_y_i} ;
  assign ext_sx = {XW'(0), start_x_i};
  assign ext_sy = {YW'(0), start_y_i};
  assign ext_gx = {XW'(0), goal_x_i};
  assign ext_gy = {YW'(0), goal_y_i};

  assign cell_in_grid = ({3'b0, cell_x_i} < 9'(GRID_WIDTH)) &&
                        ({3'b0, cell_y_i} < 9'(GRID_HEIGHT));
  assign query_ok = ({3'b0, start_x_i} < 9'(GRID_WIDTH)) &&
                    ({3'b0, start_y_i} < 9'(GRID_HEIGHT)) &&
                    ({3'b0, goal_x_i} < 9'(GRID_WIDTH)) &&
                    ({3'b0, goal_y_i} < 9'(GRID_HEIGHT)) &&
                    !((start_x_i == goal_x_i) && (start_y_i == goal_y_i));

  assign nx_s   = $signed({2'b00, cx_q}) + (XW+2)'(STEP_DX[d_q]);
  assign ny_s   = $signed({2'b00, cy_q}) + (YW+2)'(STEP_DY[d_q]);
  assign nb_out = (nx_s < 0) || (ny_s < 0) ||
                  (nx_s >= $signed((XW+2)'(GRID_WIDTH))) ||
                  (ny_s >= $signed((YW+2)'(GRID_HEIGHT)));
  assign nx_c   = nx_s[XW-1:0];
  assign ny_c   = ny_s[YW-1:0];

  assign new_cost = cost_q + (d_q[2] ? COST_W'(STEP_DIAGONAL) : COST_W'(STEP_STRAIGHT));

  assign limit = (max_len_q == 7'd0) ? 7'd1 :
                 ((max_len_q > 7'(MAX_WAYPOINTS)) ? 7'(MAX_WAYPOINTS) : max_len_q);
  assign path_pos = EXW'(n_q) - EXW'(ei_q) - EXW'(1);

  assign ext_wx = {6'b0, path_rd_q[XW-1:0]};
  assign ext_wy = {6'b0, path_rd_q[CW-1:XW]};

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      max_len_q   <= MAX_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    gx_q   <= gx_d;
    gy_q   <= gy_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    d_q    <= d_d;
    cost_q <= cost_d;
    h_q    <= h_d;
    n_q    <= n_d;
    tc_q   <= tc_d;
    ei_q   <= ei_d;
    emit_q <= emit_d;
    ovf_q  <= ovf_d;
    if (out_load) begin
      way_x_q         <= ld_x;
      way_y_q         <= ld_y;
      way_index_q     <= ld_index;
      path_count_q    <= ld_count;
      no_path_q       <= ld_no_path;
      heap_overflow_q <= ld_ovf;
      last_q          <= ld_last;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    gx_d       = gx_q;
    gy_d       = gy_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    nx_d       = nx_q;
    ny_d       = ny_q;
    d_d        = d_q;
    cost_d     = cost_q;
    h_d        = h_q;
    n_d        = n_q;
    tc_d       = tc_q;
    ei_d       = ei_q;
    emit_d     = emit_q;
    ovf_d      = ovf_q;
    rec_we     = 1'b0;
    rec_re     = 1'b0;
    rec_waddr  = clr_q;
    rec_wdata  = '0;
    rec_raddr  = cell_addr(cx_q, cy_q);
    map_we     = 1'b0;
    map_re     = 1'b0;
    map_waddr  = clr_q;
    map_wdata  = 1'b1;
    map_raddr  = cell_addr(nx_q, ny_q);
    path_we    = 1'b0;
    path_re    = 1'b0;
    path_waddr = n_q[AW-1:0];
    path_wdata = tc_q;
    path_raddr = path_pos[AW-1:0];
    hcmd       = '0;
    hpri       = '0;
    hcell      = {sy_q, sx_q};
    out_load   = 1'b0;
    ld_x       = '0;
    ld_y       = '0;
    ld_index   = '0;
    ld_count   = '0;
    ld_no_path = 1'b0;
    ld_ovf     = ovf_q;
    ld_last    = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        map_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (!action_i) begin
            map_we    = cell_in_grid;
            map_waddr = cell_addr(ext_cx[XW-1:0], ext_cy[YW-1:0]);
            map_wdata = cell_passable_i;
          end else begin
            sx_d = ext_sx[XW-1:0];
            sy_d = ext_sy[YW-1:0];
            gx_d = ext_gx[XW-1:0];
            gy_d = ext_gy[YW-1:0];
            if (query_ok) begin
              hcmd.clear = 1'b1;
              clr_d      = '0;
              state_d    = S_CLEAR;
            end else begin
              ovf_d   = 1'b0;
              state_d = S_NOPATH;
            end
          end
        end
      end
      S_CLEAR: begin
        rec_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_START;
        end
      end
      S_START: begin
        rec_we    = 1'b1;
        rec_waddr = cell_addr(sx_q, sy_q);
        rec_wdata = {1'b1, 1'b0, COST_W'(0), CW'(0)};
        hcmd.push = 1'b1;
        d_d       = 3'd7;
        state_d   = S_HWAIT;
      end
      S_HWAIT: begin
        if (!hsts.busy) begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (d_q == 3'd7) begin
          state_d = S_POP;
        end else begin
          d_d     = d_q + 3'd1;
          state_d = S_NB;
        end
      end
      S_POP: begin
        if (hsts.empty) begin
          state_d = S_GOAL_RD;
        end else begin
          hcmd.pop = 1'b1;
          state_d  = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        if (!hsts.busy) begin
          cx_d    = htop[XW-1:0];
          cy_d    = htop[CW-1:XW];
          state_d = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        rec_re  = 1'b1;
        state_d = S_CUR_CHK;
      end
      S_CUR_CHK: begin
        if (rec_rd_q[RW-2]) begin
          state_d = S_POP;
        end else begin
          rec_we    = 1'b1;
          rec_waddr = cell_addr(cx_q, cy_q);
          rec_wdata = rec_rd_q | (RW'(1) << (RW - 2));
          cost_d    = rec_rd_q[CW +: COST_W];
          if ((cx_q == gx_q) && (cy_q == gy_q)) begin
            state_d = S_GOAL_RD;
          end else begin
            d_d     = 3'd0;
            state_d = S_NB;
          end
        end
      end
      S_NB: begin
        if (nb_out) begin
          state_d = S_ADV;
        end else begin
          nx_d      = nx_c;
          ny_d      = ny_c;
          h_d       = octile(nx_c, ny_c, gx_q, gy_q);
          rec_re    = 1'b1;
          rec_raddr = cell_addr(nx_c, ny_c);
          state_d   = S_NB_REC;
        end
      end
      S_NB_REC: begin
        if (rec_rd_q[RW-2]) begin
          state_d = S_ADV;
        end else if (d_q[2]) begin
          map_re    = 1'b1;
          map_raddr = cell_addr(nx_q, cy_q);
          state_d   = S_SIDE_A;
        end else begin
          map_re  = 1'b1;
          state_d = S_NB_MAP;
        end
      end
      S_SIDE_A: begin
        if (!map_rd_q) begin
          state_d = S_ADV;
        end else begin
          map_re    = 1'b1;
          map_raddr = cell_addr(cx_q, ny_q);
          state_d   = S_SIDE_B;
        end
      end
      S_SIDE_B: begin
        if (!map_rd_q) begin
          state_d = S_ADV;
        end else begin
          map_re  = 1'b1;
          state_d = S_NB_MAP;
        end
      end
      S_NB_MAP: begin
        if (!map_rd_q && !((nx_q == gx_q) && (ny_q == gy_q))) begin
          state_d = S_ADV;
        end else if (!rec_rd_q[RW-1] || (new_cost < rec_rd_q[CW +: COST_W])) begin
          rec_we    = 1'b1;
          rec_waddr = cell_addr(nx_q, ny_q);
          rec_wdata = {1'b1, 1'b0, new_cost, cy_q, cx_q};
          hcmd.push = 1'b1;
          hpri      = PRI_W'(new_cost) + PRI_W'(h_q);
          hcell     = {ny_q, nx_q};
          state_d   = S_HWAIT;
        end else begin
          state_d = S_ADV;
        end
      end
      S_GOAL_RD: begin
        rec_re    = 1'b1;
        rec_raddr = cell_addr(gx_q, gy_q);
        state_d   = S_GOAL_CHK;
      end
      S_GOAL_CHK: begin
        ovf_d = hsts.overflow;
        if (!rec_rd_q[RW-1]) begin
          state_d = S_NOPATH;
        end else begin
          n_d     = '0;
          tc_d    = {gy_q, gx_q};
          state_d = S_TRACE;
        end
      end
      S_TRACE: begin
        if ((tc_q == {sy_q, sx_q}) || (n_q == NW'(CELLS))) begin
          emit_d  = (EXW'(n_q) < EXW'(limit)) ? 7'(n_q) : limit;
          ei_d    = '0;
          state_d = S_EMIT_RD;
        end else begin
          path_we   = 1'b1;
          n_d       = n_q + NW'(1);
          rec_re    = 1'b1;
          rec_raddr = cell_addr(tc_q[XW-1:0], tc_q[CW-1:XW]);
          state_d   = S_TRACE_W;
        end
      end
      S_TRACE_W: begin
        tc_d    = rec_rd_q[CW-1:0];
        state_d = S_TRACE;
      end
      S_EMIT_RD: begin
        path_re = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_x     = ext_wx[5:0];
          ld_y     = ext_wy[5:0];
          ld_index = ei_q[5:0];
          ld_count = emit_q;
          ld_last  = (ei_q + 7'd1 == emit_q);
          ei_d     = ei_q + 7'd1;
          state_d  = (ei_q + 7'd1 == emit_q) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_NOPATH: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_no_path = 1'b1;
          ld_last    = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign way_x_o         = way_x_q;
  assign way_y_o         = way_y_q;
  assign way_index_o     = way_index_q;
  assign path_count_o    = path_count_q;
  assign no_path_o       = no_path_q;
  assign heap_overflow_o = heap_overflow_q;
  assign last_o          = last_q;

  a_no_path_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_path_o |-> last_o && (path_count_o == 7'd0) &&
                                 (way_x_o == 6'd0) && (way_y_o == 6'd0))
    else $error("no-path transfer has a malformed payload");

  a_way_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !no_path_o |-> (path_count_o != 7'd0) &&
                                  ({1'b0, way_index_o} < path_count_o) &&
                                  (last_o == ({1'b0, way_index_o} + 7'd1 == path_count_o)))
    else $error("waypoint index inconsistent with path count");

  a_search_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i |=> in_stall_o)
    else $error("query transfer not followed by a busy block");

endmodule
`default_nettype wire
